@@ design/colour_key_palette_match_core_defines.svh @@
// Assertion macros for the colour key palette match core, used by ckpm_scan_ctrl.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef COLOUR_KEY_PALETTE_MATCH_CORE_DEFINES_SVH
`define COLOUR_KEY_PALETTE_MATCH_CORE_DEFINES_SVH
`ifndef SYNTH
`define CKPM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ckpm same-cycle check failed");
`define CKPM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ckpm next-cycle check failed");
`else
`define CKPM_ASSERT_IMP(label, ante, cons)
`define CKPM_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ design/ckpm_pkg.sv @@
// Types, constants and helper functions for the colour key palette match core.
// Depends on nothing.
package ckpm_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int ADDR_MAX_W = 8;
   localparam int DIST_W     = 10;
   localparam logic [DIST_W-1:0] DIST_INIT = '1;

   localparam logic ACT_WRITE   = 1'b0;
   localparam logic ACT_CONVERT = 1'b1;

   localparam logic [1:0] FMT_INDEXED = 2'd0;
   localparam logic [1:0] FMT_DIRECT  = 2'd1;
   localparam logic [1:0] FMT_PACKED  = 2'd2;

   localparam logic [2:0] CSR_TARGET_FORMAT   = 3'd0;
   localparam logic [2:0] CSR_ALPHA_BIT_COUNT = 3'd1;
   localparam logic [2:0] CSR_RED_BIT_COUNT   = 3'd2;
   localparam logic [2:0] CSR_GREEN_BIT_COUNT = 3'd3;
   localparam logic [2:0] CSR_BLUE_BIT_COUNT  = 3'd4;

   localparam logic [1:0] FORMAT_RESET      = FMT_INDEXED;
   localparam logic [3:0] ALPHA_BITS_RESET  = 4'd0;
   localparam logic [3:0] RED_BITS_RESET    = 4'd5;
   localparam logic [3:0] GREEN_BITS_RESET  = 4'd6;
   localparam logic [3:0] BLUE_BITS_RESET   = 4'd5;
   localparam logic [3:0] CHANNEL_BITS      = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] target_format;
      logic [3:0] alpha_bit_count;
      logic [3:0] red_bit_count;
      logic [3:0] green_bit_count;
      logic [3:0] blue_bit_count;
   } cfg_type;

   typedef struct packed {
      logic                  rd_en;
      logic [ADDR_MAX_W-1:0] rd_addr;
      logic                  wr_en;
      logic [ADDR_MAX_W-1:0] wr_addr;
      logic [23:0]           wr_data;
   } ram_req_type;

   function automatic logic [7:0] abs_diff(logic [7:0] x, logic [7:0] y);
      return (x > y) ? 8'(x - y) : 8'(y - x);
   endfunction

   function automatic logic [3:0] clamp_bits(logic [3:0] n);
      return (n > CHANNEL_BITS) ? CHANNEL_BITS : n;
   endfunction

   function automatic logic [7:0] keep_top(logic [7:0] ch, logic [3:0] n);
      if (n == 4'd0) begin
         return 8'd0;
      end
      return ch >> (CHANNEL_BITS - n);
   endfunction

   function automatic logic [31:0] pack_key(logic [31:0] key, cfg_type cfg);
      logic [3:0] ab, rb, gb, bb;
      logic [4:0] sh_g, sh_r, sh_a;
      logic [31:0] a, r, g, b;
      ab   = clamp_bits(cfg.alpha_bit_count);
      rb   = clamp_bits(cfg.red_bit_count);
      gb   = clamp_bits(cfg.green_bit_count);
      bb   = clamp_bits(cfg.blue_bit_count);
      a    = 32'(keep_top(key[31:24], ab));
      r    = 32'(keep_top(key[23:16], rb));
      g    = 32'(keep_top(key[15:8], gb));
      b    = 32'(keep_top(key[7:0], bb));
      sh_g = 5'(bb);
      sh_r = 5'(gb) + 5'(bb);
      sh_a = sh_r + 5'(rb);
      return (a << sh_a) | (r << sh_r) | (g << sh_g) | b;
   endfunction

endpackage

@@ design/ckpm_palette_ram.sv @@
// Palette memory: one write port, one registered read port, valid bit per entry.
// Depends on ckpm_pkg.
module ckpm_palette_ram
   import ckpm_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  ram_req_type ram_req,
   output logic [23:0] rd_data
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   logic [23:0]                mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [23:0]                rd_data_ff;
   logic                       rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr[IDX_W-1:0]] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr[IDX_W-1:0]];
         rd_vld_ff  <= valid_ff[ram_req.rd_addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_req.wr_en) begin
         valid_ff[ram_req.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : 24'd0;

endmodule

@@ design/ckpm_scan_ctrl.sv @@
// Item sequencer: palette scan, nearest-entry compare, format select, result register.
// Depends on ckpm_pkg and the assertion macro header.
`include "colour_key_palette_match_core_defines.svh"
module ckpm_scan_ctrl
   import ckpm_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [31:0] req_key_colour,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_key_value,
   output ram_req_type ram_req,
   input  logic [23:0] rd_data
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

   state_type         state_ff, state_in;
   logic [31:0]       key_ff, key_in;
   logic [IDX_W-1:0]  scan_addr_ff, scan_addr_in;
   logic              cmp_vld_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic [DIST_W-1:0] best_d_ff, best_d_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;

   logic              req_accept;
   logic              convert_accept;
   logic              out_free;
   logic              scanning;
   logic              done;
   logic [DIST_W-1:0] cand_d;
   logic [31:0]       result;

   assign req_accept     = req_valid && !req_stall;
   assign convert_accept = req_accept && (req_action == ACT_CONVERT);
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (convert_accept) begin
               state_in = (cfg.target_format == FMT_INDEXED) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_addr_ff == LAST_IDX) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      scanning  = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SCAN:  scanning  = 1'b1;
         ST_FLUSH: req_stall = 1'b1;
         ST_DONE:  done      = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   always_comb begin
      ram_req.rd_en   = scanning;
      ram_req.rd_addr = ADDR_MAX_W'(scan_addr_ff);
      ram_req.wr_en   = req_accept && (req_action == ACT_WRITE) &&
                        ({1'b0, req_entry_index} < 9'(PALETTE_ENTRIES));
      ram_req.wr_addr = req_entry_index;
      ram_req.wr_data = {req_red, req_green, req_blue};
   end

   assign cand_d = DIST_W'(abs_diff(rd_data[23:16], key_ff[23:16])) +
                   DIST_W'(abs_diff(rd_data[15:8], key_ff[15:8])) +
                   DIST_W'(abs_diff(rd_data[7:0], key_ff[7:0]));

   always_comb begin
      key_in       = convert_accept ? req_key_colour : key_ff;
      scan_addr_in = scanning ? scan_addr_ff + 1'b1 : '0;
      best_d_in    = best_d_ff;
      best_idx_in  = best_idx_ff;
      if (state_ff == ST_IDLE) begin
         best_d_in   = DIST_INIT;
         best_idx_in = '0;
      end else if (cmp_vld_ff && (cand_d < best_d_ff)) begin
         best_d_in   = cand_d;
         best_idx_in = cmp_idx_ff;
      end
   end

   always_comb begin
      case (cfg.target_format)
         FMT_INDEXED: result = 32'(best_idx_ff);
         FMT_DIRECT:  result = key_ff;
         FMT_PACKED:  result = pack_key(key_ff, cfg);
         default:     result = 32'd0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= scanning;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= scan_addr_ff;
      best_d_ff    <= best_d_in;
      best_idx_ff  <= best_idx_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_value = rsp_value_ff;

   `CKPM_ASSERT_IMP(a_no_write_busy, state_ff != ST_IDLE, !ram_req.wr_en)
   `CKPM_ASSERT_IMP(a_flush_last, state_ff == ST_FLUSH, cmp_vld_ff && (cmp_idx_ff == LAST_IDX))
   `CKPM_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `CKPM_ASSERT_NXT(a_convert_busy, convert_accept, state_ff != ST_IDLE)

endmodule

@@ design/colour_key_palette_match_core.sv @@
// Top level of the colour key palette match core: CSR bank, sequencer, palette memory.
// Depends on ckpm_pkg, ckpm_palette_ram and ckpm_scan_ctrl.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, entry_index, red, green, blue, key_colour
//   rsp      out        rsp_valid/rsp_stall  key_value
//   csr      in         csr_we               csr_index, csr_wdata
//
// A convert item in indexed mode scans every palette entry at one memory read per cycle,
// then passes through FLUSH and DONE; direct and packed convert items go straight to DONE.
// One item is in work at a time; the next is taken while a result waits in the rsp register.
// Reset clears the palette valid bits at once, so no clearing pass is needed.
// A stalled rsp holds its item, and req stays stalled until the sequencer is idle again.
module colour_key_palette_match_core
   import ckpm_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [31:0] req_key_colour,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_key_value,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   ram_req_type ram_req;
   logic [23:0] rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_FORMAT:   cfg_in.target_format   = csr_wdata[1:0];
            CSR_ALPHA_BIT_COUNT: cfg_in.alpha_bit_count = csr_wdata;
            CSR_RED_BIT_COUNT:   cfg_in.red_bit_count   = csr_wdata;
            CSR_GREEN_BIT_COUNT: cfg_in.green_bit_count = csr_wdata;
            CSR_BLUE_BIT_COUNT:  cfg_in.blue_bit_count  = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_format   <= FORMAT_RESET;
         cfg_ff.alpha_bit_count <= ALPHA_BITS_RESET;
         cfg_ff.red_bit_count   <= RED_BITS_RESET;
         cfg_ff.green_bit_count <= GREEN_BITS_RESET;
         cfg_ff.blue_bit_count  <= BLUE_BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ckpm_scan_ctrl #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_key_colour  (req_key_colour),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_value   (rsp_key_value),
      .ram_req         (ram_req),
      .rd_data         (rd_data)
   );

   ckpm_palette_ram #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

@@ verif/tb_colour_key_palette_match_core.sv @@
// Self-checking testbench for colour_key_palette_match_core: palette writes, indexed, direct and
// packed conversions under several register settings and handshake idle patterns.
// Depends on ckpm_pkg and the colour_key_palette_match_core RTL.
module tb_colour_key_palette_match_core;
   import ckpm_pkg::*;

   localparam logic [1:0] FMT_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 4000;
   localparam int         SETTLE_CYCLES = 300;
   localparam int         PHASE_ITEMS = 170;

   typedef struct {
      logic        action;
      logic [7:0]  entry_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] key_colour;
      bit          drain_first;
   } colour_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = ACT_WRITE;
   logic [7:0]  req_entry_index = 8'd0;
   logic [7:0]  req_red = 8'd0;
   logic [7:0]  req_green = 8'd0;
   logic [7:0]  req_blue = 8'd0;
   logic [31:0] req_key_colour = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_key_value;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_TARGET_FORMAT;
   logic [3:0]  csr_wdata = 4'd0;

   colour_item_type pending_items[$];
   logic [31:0]     expected_key_values[$];

   logic [23:0] palette_model [256];
   logic [1:0]  format_model;
   logic [3:0]  alpha_bits_model;
   logic [3:0]  red_bits_model;
   logic [3:0]  green_bits_model;
   logic [3:0]  blue_bits_model;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   bit req_took = 1'b0;

   colour_key_palette_match_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_key_colour  (req_key_colour),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_value   (rsp_key_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int channel_distance(logic [7:0] x, logic [7:0] y);
      return (x > y) ? int'(x) - int'(y) : int'(y) - int'(x);
   endfunction

   function automatic logic [31:0] nearest_palette_index(logic [31:0] key);
      int best_dist;
      int cand_dist;
      logic [31:0] best;
      best_dist = 32'h7fffffff;
      best = 32'd0;
      for (int i = 0; i < 256; i++) begin
         cand_dist = channel_distance(palette_model[i][23:16], key[23:16]) +
                     channel_distance(palette_model[i][15:8], key[15:8]) +
                     channel_distance(palette_model[i][7:0], key[7:0]);
         if (cand_dist < best_dist) begin
            best_dist = cand_dist;
            best = 32'(i);
         end
      end
      return best;
   endfunction

   function automatic int kept_bits(logic [3:0] count);
      return (count > 4'd8) ? 8 : int'(count);
   endfunction

   function automatic logic [31:0] top_bits(logic [7:0] channel, int n);
      return (n == 0) ? 32'd0 : ({24'd0, channel} >> (8 - n));
   endfunction

   function automatic logic [31:0] packed_pixel(logic [31:0] key);
      int na, nr, ng, nb;
      na = kept_bits(alpha_bits_model);
      nr = kept_bits(red_bits_model);
      ng = kept_bits(green_bits_model);
      nb = kept_bits(blue_bits_model);
      return (top_bits(key[31:24], na) << (nr + ng + nb)) |
             (top_bits(key[23:16], nr) << (ng + nb)) |
             (top_bits(key[15:8], ng) << nb) |
             top_bits(key[7:0], nb);
   endfunction

   function automatic logic [31:0] predict_key_value(logic [31:0] key);
      case (format_model)
         FMT_INDEXED: return nearest_palette_index(key);
         FMT_DIRECT:  return key;
         FMT_PACKED:  return packed_pixel(key);
         default:     return 32'd0;
      endcase
   endfunction

   function automatic colour_item_type write_item(logic [7:0] index, logic [7:0] r,
                                                  logic [7:0] g, logic [7:0] b);
      colour_item_type item;
      item.action = ACT_WRITE;
      item.entry_index = index;
      item.red = r;
      item.green = g;
      item.blue = b;
      item.key_colour = $urandom;
      item.drain_first = 1'b0;
      return item;
   endfunction

   function automatic colour_item_type convert_item(logic [31:0] key);
      colour_item_type item;
      item.action = ACT_CONVERT;
      item.entry_index = 8'($urandom);
      item.red = 8'($urandom);
      item.green = 8'($urandom);
      item.blue = 8'($urandom);
      item.key_colour = key;
      item.drain_first = 1'b0;
      return item;
   endfunction

   function automatic logic [7:0] jitter(logic [7:0] c);
      int v;
      v = int'(c) + $urandom_range(6) - 3;
      if (v < 0) begin
         v = 0;
      end else if (v > 255) begin
         v = 255;
      end
      return 8'(v);
   endfunction

   function automatic logic [7:0] random_channel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   always @(negedge clock) begin
      colour_item_type next_item;
      if (!req_valid || req_took) begin
         if (!reset && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct &&
             !(pending_items[0].drain_first && expected_key_values.size() > 0)) begin
            next_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_action <= next_item.action;
            req_entry_index <= next_item.entry_index;
            req_red <= next_item.red;
            req_green <= next_item.green;
            req_blue <= next_item.blue;
            req_key_colour <= next_item.key_colour;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      logic [31:0] want;
      bit rsp_took;
      req_took = req_valid && !req_stall && !reset;
      rsp_took = rsp_valid && !rsp_stall && !reset;
      if (rsp_took) begin
         if (expected_key_values.size() == 0) begin
            $display("%0t unexpected result: expected none actual key_value %h",
                     $time, rsp_key_value);
            mismatches++;
         end else begin
            want = expected_key_values.pop_front();
            if (rsp_key_value !== want) begin
               $display("%0t key_value mismatch: expected %h actual %h",
                        $time, want, rsp_key_value);
               mismatches++;
            end
         end
      end
      if (req_took) begin
         if (req_action == ACT_WRITE) begin
            palette_model[req_entry_index] = {req_red, req_green, req_blue};
         end else begin
            expected_key_values.push_back(predict_key_value(req_key_colour));
         end
      end
      if (reset || req_took || rsp_took) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
            $display("colour_key_palette_match_core verification failed");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_items.size() > 0 || req_valid || expected_key_values.size() > 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(logic [3:0] fmt_data, logic [3:0] a, logic [3:0] r,
                             logic [3:0] g, logic [3:0] b);
      logic [2:0] indexes [5];
      logic [3:0] values [5];
      indexes = '{CSR_TARGET_FORMAT, CSR_ALPHA_BIT_COUNT, CSR_RED_BIT_COUNT,
                  CSR_GREEN_BIT_COUNT, CSR_BLUE_BIT_COUNT};
      values = '{fmt_data, a, r, g, b};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= indexes[i];
         csr_wdata <= values[i];
         @(negedge clock);
         case (indexes[i])
            CSR_TARGET_FORMAT:   format_model = values[i][1:0];
            CSR_ALPHA_BIT_COUNT: alpha_bits_model = values[i];
            CSR_RED_BIT_COUNT:   red_bits_model = values[i];
            CSR_GREEN_BIT_COUNT: green_bits_model = values[i];
            CSR_BLUE_BIT_COUNT:  blue_bits_model = values[i];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   task automatic start_phase(int send_pct, int stall_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic push_random(int count, int write_pct);
      colour_item_type item;
      logic [23:0] target;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < write_pct) begin
            item = write_item(8'($urandom), random_channel(), random_channel(), random_channel());
         end else if ($urandom_range(2) == 0) begin
            item = convert_item($urandom);
         end else begin
            target = palette_model[$urandom_range(255)];
            item = convert_item({8'($urandom), jitter(target[23:16]), jitter(target[15:8]),
                                 jitter(target[7:0])});
         end
         item.drain_first = ($urandom_range(49) == 0);
         pending_items.push_back(item);
      end
   endtask

   initial begin
      colour_item_type item;
      logic [1:0] fmt;
      logic [3:0] counts [4];
      for (int i = 0; i < 256; i++) begin
         palette_model[i] = 24'd0;
      end
      format_model = FORMAT_RESET;
      alpha_bits_model = ALPHA_BITS_RESET;
      red_bits_model = RED_BITS_RESET;
      green_bits_model = GREEN_BITS_RESET;
      blue_bits_model = BLUE_BITS_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // indexed with reset palette, entry 255, first-index exact match, tie
      start_phase(0, 0);
      pending_items.push_back(convert_item(32'h0000_0000));
      pending_items.push_back(convert_item(32'hffff_ffff));
      pending_items.push_back(write_item(8'd255, 8'hff, 8'hff, 8'hff));
      item = convert_item(32'hffff_ffff);
      item.drain_first = 1'b1;
      pending_items.push_back(item);
      pending_items.push_back(write_item(8'd7, 8'h12, 8'h34, 8'h56));
      pending_items.push_back(write_item(8'd200, 8'h12, 8'h34, 8'h56));
      pending_items.push_back(convert_item(32'h8012_3456));
      pending_items.push_back(write_item(8'd40, 8'd10, 8'd10, 8'd10));
      pending_items.push_back(write_item(8'd41, 8'd30, 8'd30, 8'd30));
      pending_items.push_back(convert_item(32'h0014_1414));

      wait_drained();
      set_config({2'b00, FMT_DIRECT}, ALPHA_BITS_RESET, RED_BITS_RESET, GREEN_BITS_RESET,
                 BLUE_BITS_RESET);
      start_phase(0, 0);
      pending_items.push_back(convert_item(32'h0000_0000));
      pending_items.push_back(convert_item(32'hffff_ffff));
      pending_items.push_back(convert_item(32'ha5c3_3c5a));

      wait_drained();
      set_config({2'b00, FMT_PACKED}, ALPHA_BITS_RESET, RED_BITS_RESET, GREEN_BITS_RESET,
                 BLUE_BITS_RESET);
      start_phase(0, 0);
      pending_items.push_back(convert_item(32'hffff_ffff));
      pending_items.push_back(convert_item(32'h1234_5678));

      wait_drained();
      set_config({2'b00, FMT_PACKED}, 4'd8, 4'd8, 4'd8, 4'd8);
      start_phase(0, 0);
      pending_items.push_back(convert_item(32'hdead_beef));

      wait_drained();
      set_config({2'b00, FMT_PACKED}, 4'd0, 4'd0, 4'd0, 4'd0);
      start_phase(0, 0);
      pending_items.push_back(convert_item(32'hffff_ffff));

      wait_drained();
      set_config({2'b00, FMT_PACKED}, 4'd15, 4'd15, 4'd15, 4'd15);
      start_phase(0, 0);
      pending_items.push_back(convert_item(32'h89ab_cdef));

      wait_drained();
      set_config({2'b00, FMT_UNUSED}, 4'd3, 4'd4, 4'd2, 4'd7);
      start_phase(0, 0);
      pending_items.push_back(convert_item(32'hffff_ffff));

      for (int p = 0; p < 10; p++) begin
         wait_drained();
         case (p % 3)
            0: fmt = FMT_INDEXED;
            1: fmt = FMT_PACKED;
            default: fmt = FMT_DIRECT;
         endcase
         if (p == 5) begin
            fmt = FMT_UNUSED;
         end
         for (int c = 0; c < 4; c++) begin
            case (p)
               1: counts[c] = 4'd15;
               4: counts[c] = 4'd8;
               7: counts[c] = 4'd0;
               default: counts[c] = 4'($urandom_range(15));
            endcase
         end
         set_config({2'($urandom_range(3)), fmt}, counts[0], counts[1], counts[2], counts[3]);
         case (p % 4)
            0: start_phase(0, 0);
            1: start_phase(81, 0);
            2: start_phase(0, 81);
            default: start_phase(35, 35);
         endcase
         push_random(PHASE_ITEMS, (fmt == FMT_INDEXED) ? 55 : 35);
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("colour_key_palette_match_core verification clean");
      end else begin
         $display("colour_key_palette_match_core verification failed");
      end
      $finish;
   end
endmodule

@@ colour_key_palette_match_core.f @@
+incdir+design
design/ckpm_pkg.sv
design/ckpm_palette_ram.sv
design/ckpm_scan_ctrl.sv
design/colour_key_palette_match_core.sv
verif/tb_colour_key_palette_match_core.sv
